[rtl/psteer_pkg.sv]
`timescale 1ns / 1ps

package psteer_pkg;

  // Default values of the top-level parameters.
  localparam int FRAC_BITS_DEF = 16;
  localparam int SUM_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int REFL_W      = 7;
  localparam int GAIN_W      = 24;
  localparam int SET_W       = 8;
  localparam int LIM_W       = 7;
  localparam int ERR_W       = 9;
  localparam int DIFF_W      = 10;
  localparam int DRIVE_W     = 9;
  localparam int STEER_W     = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 48;
  localparam int STAGES      = 5;

  // Register reset values.
  localparam logic [GAIN_W-1:0] PROP_RST   = 24'd65536;
  localparam logic [GAIN_W-1:0] INT_RST    = 24'd33;
  localparam logic [GAIN_W-1:0] DERIV_RST  = 24'd655360;
  localparam logic [SET_W-1:0]  SET_RST    = 8'd0;
  localparam logic [LIM_W-1:0]  LIM_RST    = 7'd100;
  localparam logic [LIM_W-1:0]  BASE_RST   = 7'd100;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP     = 3'd0,
    REG_INT      = 3'd1,
    REG_DERIV    = 3'd2,
    REG_SETPOINT = 3'd3,
    REG_LIMIT    = 3'd4,
    REG_BASE     = 3'd5
  } cfg_reg_t;

  // Load strobes of the pipeline stages.
  typedef struct packed {
    logic ld_in;
    logic ld_err;
    logic ld_prod;
    logic ld_clamp;
    logic ld_out;
  } pipe_ld_t;

endpackage

[rtl/psteer_err.sv]
`timescale 1ns / 1ps

module psteer_err
  import psteer_pkg::*;
#(
  parameter int SUM_BITS = SUM_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pipe_ld_t                   ld,
  input  logic [REFL_W-1:0]          refl_left,
  input  logic [REFL_W-1:0]          refl_right,
  input  logic signed [SET_W-1:0]    setpoint,
  output logic signed [ERR_W-1:0]    err_o,
  output logic signed [DIFF_W-1:0]   diff_o,
  output logic signed [SUM_BITS-1:0] sum_o
);

  logic [REFL_W-1:0]          left_r, right_r;
  logic signed [ERR_W-1:0]    prev_err_r;
  logic signed [SUM_BITS-1:0] sum_r, sum_nxt;
  logic signed [ERR_W-1:0]    err_nxt, err_r;
  logic signed [DIFF_W-1:0]   diff_nxt, diff_r;
  logic signed [DIFF_W-1:0]   inc;
  logic signed [SUM_BITS:0]   sum_wide;
  logic signed [SUM_BITS-1:0] sum_q_r;
  logic signed [ERR_W-1:0]    rl_diff;

  always_comb begin
    rl_diff  = $signed({2'b00, right_r}) - $signed({2'b00, left_r});
    err_nxt  = ERR_W'(setpoint) - rl_diff;
    inc      = DIFF_W'(err_nxt) + DIFF_W'(prev_err_r);
    diff_nxt = DIFF_W'(err_nxt) - DIFF_W'(prev_err_r);
    sum_wide = (SUM_BITS + 1)'(sum_r) + (SUM_BITS + 1)'(inc);
    // Saturate when the two top bits of the widened sum disagree.
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_nxt = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                   : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sum_nxt = sum_wide[SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_in) begin
      left_r  <= refl_left;
      right_r <= refl_right;
    end
    if (ld.ld_err) begin
      err_r   <= err_nxt;
      diff_r  <= diff_nxt;
      sum_q_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      sum_r      <= '0;
    end else if (ld.ld_err) begin
      prev_err_r <= err_nxt;
      sum_r      <= sum_nxt;
    end
  end

  assign err_o  = err_r;
  assign diff_o = diff_r;
  assign sum_o  = sum_q_r;

endmodule

[rtl/psteer_mul.sv]
`timescale 1ns / 1ps

module psteer_mul
  import psteer_pkg::*;
#(
  parameter int SUM_BITS = SUM_BITS_DEF,
  localparam int LO_W    = SUM_BITS / 2,
  localparam int HI_W    = SUM_BITS - LO_W,
  localparam int PP_W    = GAIN_W + ERR_W,
  localparam int PD_W    = GAIN_W + DIFF_W,
  localparam int PL_W    = GAIN_W + LO_W + 1,
  localparam int PH_W    = GAIN_W + HI_W
) (
  input  logic                       clk,
  input  pipe_ld_t                   ld,
  input  logic signed [GAIN_W-1:0]   prop_gain,
  input  logic signed [GAIN_W-1:0]   int_gain,
  input  logic signed [GAIN_W-1:0]   deriv_gain,
  input  logic signed [ERR_W-1:0]    err,
  input  logic signed [DIFF_W-1:0]   diff,
  input  logic signed [SUM_BITS-1:0] err_sum,
  output logic signed [PP_W-1:0]     p_prop_o,
  output logic signed [PD_W-1:0]     p_der_o,
  output logic signed [PL_W-1:0]     p_ilo_o,
  output logic signed [PH_W-1:0]     p_ihi_o
);

  // The integral product is split into two partial products on the
  // halves of the sum; they are recombined after this register.
  logic signed [LO_W:0]   sum_lo;
  logic signed [HI_W-1:0] sum_hi;
  logic signed [PP_W-1:0] p_prop_r;
  logic signed [PD_W-1:0] p_der_r;
  logic signed [PL_W-1:0] p_ilo_r;
  logic signed [PH_W-1:0] p_ihi_r;

  assign sum_lo = $signed({1'b0, err_sum[LO_W-1:0]});
  assign sum_hi = err_sum[SUM_BITS-1:LO_W];

  always_ff @(posedge clk) begin
    if (ld.ld_prod) begin
      p_prop_r <= PP_W'(prop_gain) * PP_W'(err);
      p_der_r  <= PD_W'(deriv_gain) * PD_W'(diff);
      p_ilo_r  <= PL_W'(int_gain) * PL_W'(sum_lo);
      p_ihi_r  <= PH_W'(int_gain) * PH_W'(sum_hi);
    end
  end

  assign p_prop_o = p_prop_r;
  assign p_der_o  = p_der_r;
  assign p_ilo_o  = p_ilo_r;
  assign p_ihi_o  = p_ihi_r;

endmodule

[rtl/psteer_out.sv]
`timescale 1ns / 1ps

module psteer_out
  import psteer_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SUM_BITS  = SUM_BITS_DEF,
  localparam int LO_W     = SUM_BITS / 2,
  localparam int HI_W     = SUM_BITS - LO_W,
  localparam int PP_W     = GAIN_W + ERR_W,
  localparam int PD_W     = GAIN_W + DIFF_W,
  localparam int PL_W     = GAIN_W + LO_W + 1,
  localparam int PH_W     = GAIN_W + HI_W
) (
  input  logic                     clk,
  input  pipe_ld_t                 ld,
  input  logic signed [PP_W-1:0]   p_prop,
  input  logic signed [PD_W-1:0]   p_der,
  input  logic signed [PL_W-1:0]   p_ilo,
  input  logic signed [PH_W-1:0]   p_ihi,
  input  logic [LIM_W-1:0]         steer_limit,
  input  logic [LIM_W-1:0]         base_speed,
  output logic [DRIVE_W-1:0]       left_drive,
  output logic [DRIVE_W-1:0]       right_drive,
  output logic [STEER_W-1:0]       steer_value
);

  localparam int SW = GAIN_W + SUM_BITS + 3;
  localparam int CW = LIM_W + FRAC_BITS + 1;
  localparam int DW = CW + 1;
  localparam int XW = (CW > STEER_W) ? CW : STEER_W;

  logic signed [SW-1:0]   total, lim_wide;
  logic signed [CW-1:0]   lim_s, base_s;
  logic signed [CW-1:0]   clamp_nxt, clamp_r;
  logic signed [DW-1:0]   b_plus, b_minus;
  logic signed [XW-1:0]   steer_x;
  logic [DRIVE_W-1:0]     left_r, right_r;
  logic [STEER_W-1:0]     steer_r;

  always_comb begin
    total    = SW'(p_prop) + SW'(p_der) + SW'(p_ilo) + (SW'(p_ihi) <<< LO_W);
    lim_s    = $signed({1'b0, steer_limit, {FRAC_BITS{1'b0}}});
    lim_wide = SW'(lim_s);
    if (total > lim_wide) begin
      clamp_nxt = lim_s;
    end else if (total < -lim_wide) begin
      clamp_nxt = -lim_s;
    end else begin
      clamp_nxt = CW'(total);
    end
  end

  // Arithmetic right shift rounds towards minus infinity.
  always_comb begin
    base_s  = $signed({1'b0, base_speed, {FRAC_BITS{1'b0}}});
    b_plus  = DW'(base_s) + DW'(clamp_r);
    b_minus = DW'(base_s) - DW'(clamp_r);
    steer_x = XW'(clamp_r);
  end

  always_ff @(posedge clk) begin
    if (ld.ld_clamp) begin
      clamp_r <= clamp_nxt;
    end
    if (ld.ld_out) begin
      left_r  <= DRIVE_W'(b_plus >>> FRAC_BITS);
      right_r <= DRIVE_W'(b_minus >>> FRAC_BITS);
      steer_r <= steer_x[STEER_W-1:0];
    end
  end

  assign left_drive  = left_r;
  assign right_drive = right_r;
  assign steer_value = steer_r;

endmodule

[rtl/pid_line_steering.sv]
`timescale 1ns / 1ps

// PID steering for a two-sensor line follower. Each input item carries a left
// and a right reflection reading; the block forms the error as setpoint minus
// (right - left), keeps the previous error and a saturating sum of the error
// plus the previous error, and returns one result item per input item with the
// clamped steering value (signed, FRAC_BITS fraction bits) and the two wheel
// speeds, each the floor of base power plus or minus the steering value. The
// block takes one item per clock cycle while the output is not stalled. An
// item passes through five register stages in order (input, error and state
// update, multiply, sum and clamp, output). The error sum is updated within
// the error stage, which is what lets consecutive items follow each other on
// every clock. Each stage holds its item while the stage after it is full and
// cannot move on, so a stalled output fills empty stages before the input
// stops taking items; when the output holds no item the input is always ready.
// Gains, setpoint, limit and base power are to be written through the
// configuration port only while the block is idle; the block itself does not
// enforce this, and the controller state is cleared only by reset.

module pid_line_steering
  import psteer_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SUM_BITS  = SUM_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input items.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // [6:0] refl_left, [13:7] refl_right
  // Result items.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // [8:0] left_drive, [17:9] right_drive,
                                             // [41:18] steer_value
  // Configuration writes.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int LO_W = SUM_BITS / 2;
  localparam int HI_W = SUM_BITS - LO_W;
  localparam int PP_W = GAIN_W + ERR_W;
  localparam int PD_W = GAIN_W + DIFF_W;
  localparam int PL_W = GAIN_W + LO_W + 1;
  localparam int PH_W = GAIN_W + HI_W;

  // Configuration registers.
  logic [GAIN_W-1:0] prop_r, int_r, deriv_r;
  logic [SET_W-1:0]  set_r;
  logic [LIM_W-1:0]  lim_r, base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_r  <= PROP_RST;
      int_r   <= INT_RST;
      deriv_r <= DERIV_RST;
      set_r   <= SET_RST;
      lim_r   <= LIM_RST;
      base_r  <= BASE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROP:     prop_r  <= cfg_wdata[GAIN_W-1:0];
        REG_INT:      int_r   <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV:    deriv_r <= cfg_wdata[GAIN_W-1:0];
        REG_SETPOINT: set_r   <= cfg_wdata[SET_W-1:0];
        REG_LIMIT:    lim_r   <= cfg_wdata[LIM_W-1:0];
        REG_BASE:     base_r  <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline occupancy. A stage can take an item when it is empty or when
  // the stage after it is taking its item in the same cycle.
  logic [STAGES-1:0] vld_r, vld_nxt, rdy, src_vld;
  pipe_ld_t          ld;

  always_comb begin
    rdy[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    src_vld = {vld_r[STAGES-2:0], in_tvalid};
    for (int k = 0; k < STAGES; k++) begin
      vld_nxt[k] = rdy[k] ? src_vld[k] : vld_r[k];
    end
    ld.ld_in    = rdy[0] && src_vld[0];
    ld.ld_err   = rdy[1] && src_vld[1];
    ld.ld_prod  = rdy[2] && src_vld[2];
    ld.ld_clamp = rdy[3] && src_vld[3];
    ld.ld_out   = rdy[4] && src_vld[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[STAGES-1];

  // Datapath.
  logic signed [ERR_W-1:0]    err;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [SUM_BITS-1:0] err_sum;
  logic signed [PP_W-1:0]     p_prop;
  logic signed [PD_W-1:0]     p_der;
  logic signed [PL_W-1:0]     p_ilo;
  logic signed [PH_W-1:0]     p_ihi;
  logic [DRIVE_W-1:0]         left_drive, right_drive;
  logic [STEER_W-1:0]         steer_value;

  psteer_err #(
    .SUM_BITS (SUM_BITS)
  ) u_err (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ld),
    .refl_left  (in_tdata[REFL_W-1:0]),
    .refl_right (in_tdata[2*REFL_W-1:REFL_W]),
    .setpoint   ($signed(set_r)),
    .err_o      (err),
    .diff_o     (diff),
    .sum_o      (err_sum)
  );

  psteer_mul #(
    .SUM_BITS (SUM_BITS)
  ) u_mul (
    .clk        (clk),
    .ld         (ld),
    .prop_gain  ($signed(prop_r)),
    .int_gain   ($signed(int_r)),
    .deriv_gain ($signed(deriv_r)),
    .err        (err),
    .diff       (diff),
    .err_sum    (err_sum),
    .p_prop_o   (p_prop),
    .p_der_o    (p_der),
    .p_ilo_o    (p_ilo),
    .p_ihi_o    (p_ihi)
  );

  psteer_out #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_BITS  (SUM_BITS)
  ) u_out (
    .clk         (clk),
    .ld          (ld),
    .p_prop      (p_prop),
    .p_der       (p_der),
    .p_ilo       (p_ilo),
    .p_ihi       (p_ihi),
    .steer_limit (lim_r),
    .base_speed  (base_r),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .steer_value (steer_value)
  );

  assign out_tdata = {{(OUT_DATA_W - 2*DRIVE_W - STEER_W){1'b0}},
                      steer_value, right_drive, left_drive};

endmodule

[rtl/psteer_chk.sv]
`timescale 1ns / 1ps

module psteer_chk
  import psteer_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A result that is held back stays put until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or vanished");

  // No result is left over from before reset.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // With the output empty, every stage can move, so the input is ready.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the output holds nothing");

  // A non-negative steering value never slows the left wheel below the
  // right one (holds while the steering field does not wrap).
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[41] |->
      $signed(out_tdata[8:0]) >= $signed(out_tdata[17:9]))
    else $error("wheel speeds disagree with the steering sign");

endmodule

bind pid_line_steering psteer_chk u_psteer_chk (.*);

[tb/steer_checker.sv]
`timescale 1ns / 1ps

// Watches the input, result and configuration ports of the steering block,
// predicts each result item from its own copy of the controller state and
// compares every accepted result with the oldest prediction.
module steer_checker
  import psteer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    waiting
);

  localparam int     FRAC     = FRAC_BITS_DEF;
  localparam int     SUM      = SUM_BITS_DEF;
  localparam longint PROD_CAP = longint'(1) << 60;

  typedef struct {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic signed [STEER_W-1:0] steer_value;
  } drive_t;

  drive_t drive_expected[$];

  logic signed [GAIN_W-1:0] kp = PROP_RST;
  logic signed [GAIN_W-1:0] ki = INT_RST;
  logic signed [GAIN_W-1:0] kd = DERIV_RST;
  logic signed [SET_W-1:0]  sp = SET_RST;
  logic [LIM_W-1:0]         lim = LIM_RST;
  logic [LIM_W-1:0]         base = BASE_RST;
  longint                   prev_err = 0;
  longint                   err_sum = 0;

  // Advances the controller state by one reading pair and returns the drive.
  function automatic drive_t predict_drive(input logic [REFL_W-1:0] refl_l,
                                           input logic [REFL_W-1:0] refl_r);
    longint err, steer, isum, lim_fx, base_fx, sum_max, sum_min;
    drive_t d;
    sum_max = (longint'(1) << (SUM - 1)) - 1;
    sum_min = -sum_max - 1;
    err = longint'(sp) - (longint'(refl_r) - longint'(refl_l));
    err_sum = err_sum + err + prev_err;
    if (err_sum > sum_max) err_sum = sum_max;
    if (err_sum < sum_min) err_sum = sum_min;
    isum = longint'(ki) * err_sum;
    if (isum > PROD_CAP) isum = PROD_CAP;
    if (isum < -PROD_CAP) isum = -PROD_CAP;
    steer = longint'(kp) * err + isum + longint'(kd) * (err - prev_err);
    lim_fx = longint'(lim) << FRAC;
    if (steer > lim_fx) steer = lim_fx;
    if (steer < -lim_fx) steer = -lim_fx;
    base_fx = longint'(base) << FRAC;
    // An arithmetic shift of a signed value rounds towards minus infinity.
    d.left_drive  = DRIVE_W'((base_fx + steer) >>> FRAC);
    d.right_drive = DRIVE_W'((base_fx - steer) >>> FRAC);
    d.steer_value = STEER_W'(steer);
    prev_err = err;
    return d;
  endfunction

  task automatic check_field(input string what, input logic signed [STEER_W-1:0] want,
                             input logic signed [STEER_W-1:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    drive_t d;
    if (!rst_n) begin
      kp = PROP_RST;
      ki = INT_RST;
      kd = DERIV_RST;
      sp = SET_RST;
      lim = LIM_RST;
      base = BASE_RST;
      prev_err = 0;
      err_sum = 0;
      drive_expected.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP:     kp = cfg_wdata;
          REG_INT:      ki = cfg_wdata;
          REG_DERIV:    kd = cfg_wdata;
          REG_SETPOINT: sp = cfg_wdata[SET_W-1:0];
          REG_LIMIT:    lim = cfg_wdata[LIM_W-1:0];
          REG_BASE:     base = cfg_wdata[LIM_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (drive_expected.size() == 0) begin
          $display("%0t unexpected result: expected none, got %h", $time, out_tdata);
          fail_count++;
        end else begin
          d = drive_expected.pop_front();
          check_field("left_drive", STEER_W'(d.left_drive),
                      STEER_W'($signed(out_tdata[8:0])));
          check_field("right_drive", STEER_W'(d.right_drive),
                      STEER_W'($signed(out_tdata[17:9])));
          check_field("steer_value", d.steer_value, $signed(out_tdata[41:18]));
        end
      end
      if (in_tvalid && in_tready)
        drive_expected.push_back(predict_drive(in_tdata[6:0], in_tdata[13:7]));
    end
    waiting = drive_expected.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the line-steering PID block. The checker beside the
// block does all the prediction and comparison; this module only produces
// reading pairs, register settings and back-pressure, and reports the outcome.
module tb;
  import psteer_pkg::*;

  // A stretch of this many cycles in which no item moves on either side is
  // taken as a hang. The longest correct pause is the long receiver hold-off.
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 220;
  localparam int CALM_ITEMS  = 150;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // [6:0] refl_left, [13:7] refl_right
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [8:0] left_drive, [17:9] right_drive,
                                           // [41:18] steer_value
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PROP;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int waiting;
  int idle_cycles = 0;

  // Shared between the sender and the receiver: a request for one long
  // hold-off, and the final stretch in which neither side idles.
  bit hold_req = 1'b0;
  bit calm = 1'b0;

  // Most recent reading pair, so that well-formed sequences drift like a
  // robot following a line edge rather than jumping about.
  int last_l = 50;
  int last_r = 50;

  always #1 clk = ~clk;

  pid_line_steering dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  steer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  // Watchdog: any accepted item on either side restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver. Each pass makes exactly one assignment to out_tready and then
  // waits for a clock edge, so ready is never lowered and raised in one step.
  initial begin
    forever begin
      if (hold_req) begin
        // The long hold-off lets the pipeline fill and stall its input.
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one reading pair and holds it until the block takes it. The valid
  // line is left high afterwards unless a random gap follows, so a following
  // item keeps it high without a second assignment in the same step.
  task automatic send_item(input int refl_l, input int refl_r);
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, 7'(refl_r), 7'(refl_l)};
    do @(posedge clk); while (!in_tready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Stops offering items and waits until every predicted result has come
  // back, then waits longer to cover the pipeline depth.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (STAGES + 3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Writes every register in turn. Only called while the block is idle.
  task automatic load_settings(input logic [GAIN_W-1:0] prop, input logic [GAIN_W-1:0] integ,
                               input logic [GAIN_W-1:0] deriv, input logic [SET_W-1:0] setp,
                               input logic [LIM_W-1:0] limit, input logic [LIM_W-1:0] base);
    write_reg(REG_PROP, prop);
    write_reg(REG_INT, integ);
    write_reg(REG_DERIV, deriv);
    write_reg(REG_SETPOINT, CFG_DATA_W'(setp));
    write_reg(REG_LIMIT, CFG_DATA_W'(limit));
    write_reg(REG_BASE, CFG_DATA_W'(base));
    cfg_we <= 1'b0;
  endtask

  // Gains of moderate size so that the clamp is reached only some of the
  // time; now and then a gain is fully random across all 24 bits.
  function automatic logic [GAIN_W-1:0] pick_gain(input int span);
    if ($urandom_range(0, 4) == 0) return GAIN_W'($urandom);
    return GAIN_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic random_settings();
    load_settings(pick_gain(4 << 16), pick_gain(4096), pick_gain(16 << 16),
                  SET_W'($urandom), LIM_W'($urandom_range(0, 127)),
                  LIM_W'($urandom_range(0, 127)));
  endtask

  function automatic int drift(input int v);
    int n;
    n = v + int'($urandom_range(0, 10)) - 5;
    if (n < 0) n = 0;
    if (n > 100) n = 100;
    return n;
  endfunction

  // Mostly drifting readings within the sensor range, some uniform jumps,
  // and an occasional pair from the whole 7-bit field, which may exceed 100.
  task automatic random_item();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      last_l = drift(last_l);
      last_r = drift(last_r);
    end else if (k < 9) begin
      last_l = $urandom_range(0, 100);
      last_r = $urandom_range(0, 100);
    end else begin
      last_l = $urandom_range(0, 127);
      last_r = $urandom_range(0, 127);
    end
    send_item(last_l, last_r);
  endtask

  // Reading pairs for the directed part: both sensors dark and bright, each
  // sensor alone at full scale, the top of the 7-bit field beyond 100, and a
  // few near-balanced pairs.
  int dir_l[12] = '{0, 100, 0, 100, 127, 0, 127, 50, 1, 64, 85, 0};
  int dir_r[12] = '{0, 0, 100, 100, 0, 127, 127, 50, 2, 63, 42, 0};

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values of all registers, with the controller state fresh.
    for (int i = 0; i < 12; i++) send_item(dir_l[i], dir_r[i]);
    drain();

    // Largest gains, setpoint and limits of 100: the steering clamps hard.
    load_settings(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 8'd100, 7'd100, 7'd100);
    for (int i = 0; i < 6; i++) send_item(dir_l[i], dir_r[i]);
    drain();

    // Most negative gains, a setpoint of -100, zero limit and zero base power.
    load_settings(24'h800000, 24'h800000, 24'h800000, 8'h9C, 7'd0, 7'd0);
    for (int i = 6; i < 12; i++) send_item(dir_l[i], dir_r[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        // Registers beyond their stated ranges are used as written.
        load_settings(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                      8'h80, 7'd127, 7'd127);
      end else if (p == 3) begin
        load_settings(pick_gain(4 << 16), pick_gain(4096), pick_gain(16 << 16),
                      8'h7F, 7'd127, 7'd0);
      end else begin
        random_settings();
      end
      // In the first phase the receiver holds off for a long while and the
      // sender keeps offering items, so the block fills and stalls.
      if (p == 0) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // In the second phase the sender pauses once until all results are in.
        if (p == 1 && i == PHASE_ITEMS / 2) drain();
        random_item();
      end
      drain();
    end

    // Final stretch at full rate on both sides.
    random_settings();
    calm = 1'b1;
    for (int i = 0; i < CALM_ITEMS; i++) random_item();
    drain();

    // A short tail catches any result item that nothing asked for.
    repeat (2 * STAGES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
